// ===== hdl/arsc_pkg.sv =====
// Shared types and constants for the serial response stream classifier.
// No dependencies; imported by every module under hdl/.
package arsc_pkg;

  // Store sizes and the widths that follow from them
  localparam int unsigned RESP_DEPTH  = 256;
  localparam int unsigned DATA_DEPTH  = 1024;
  localparam int unsigned RESP_FILL_W = $clog2(RESP_DEPTH + 1);
  localparam int unsigned DATA_FILL_W = $clog2(DATA_DEPTH + 1);

  // Fixed field widths of the result item
  localparam int unsigned WIDX_W = 10;
  localparam int unsigned CNT_W  = 9;

  // Recent-byte window (also the longest completion pattern) and data line head
  localparam int unsigned WIN_BYTES  = 16;
  localparam int unsigned RUN_W      = $clog2(WIN_BYTES + 1);
  localparam int unsigned PAT_SH_W   = $clog2(WIN_BYTES);
  localparam int unsigned HEAD_BYTES = 8;
  localparam int unsigned HEAD_IDX_W = $clog2(HEAD_BYTES);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam logic [RUN_W-1:0] PAT_LEN_RESET = RUN_W'(4);

  // Fixed reply texts, first character in the most significant byte
  localparam logic [7:0] CR = 8'h0D;
  localparam logic [7:0] LF = 8'h0A;

  localparam int unsigned SEND_OK_LEN = 9;
  localparam int unsigned LINK_LEN    = 6;
  localparam int unsigned LINKED_LEN  = 8;
  localparam int unsigned UNLINK_LEN  = 8;
  localparam int unsigned DATA_OK_LEN = 6;

  localparam logic [8*SEND_OK_LEN-1:0] TXT_SEND_OK = {"SEND OK", CR, LF};
  localparam logic [8*LINK_LEN-1:0]    TXT_LINK    = {"Link", CR, LF};
  localparam logic [8*LINKED_LEN-1:0]  TXT_LINKED  = {"Linked", CR, LF};
  localparam logic [8*UNLINK_LEN-1:0]  TXT_UNLINK  = {"Unlink", CR, LF};
  localparam logic [8*DATA_OK_LEN-1:0] TXT_DATA_OK = {CR, LF, "OK", CR, LF};

  typedef enum logic [2:0] {
    REQ_BYTE      = 3'd0,
    REQ_CAPTURE   = 3'd1,
    REQ_SEND_WAIT = 3'd2,
    REQ_WAIT_END  = 3'd3,
    REQ_RELEASE   = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'b001,
    MODE_CAPTURE = 3'b010,
    MODE_SEND    = 3'b100
  } mode_e;

  typedef enum logic [3:0] {
    EV_NONE       = 4'd0,
    EV_DONE       = 4'd1,
    EV_SEND_OK    = 4'd2,
    EV_LINK       = 4'd3,
    EV_UNLINK     = 4'd4,
    EV_DATA_READY = 4'd5,
    EV_RESP_OVF   = 4'd6,
    EV_DATA_OVF   = 4'd7,
    EV_BUSY       = 4'd8
  } event_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LOW  = 2'd0,
    CFG_PAT_HIGH = 2'd1,
    CFG_PAT_LEN  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic              write_valid;
    logic              write_target;
    logic [WIDX_W-1:0] write_index;
    logic [7:0]        write_byte;
    logic [3:0]        event_code;
    logic [CNT_W-1:0]  response_count;
    logic              waiting;
  } out_item_t;

  // pattern byte 0 in bits 7:0; pattern_len already clamped to 1..WIN_BYTES
  typedef struct packed {
    logic [8*WIN_BYTES-1:0] pattern;
    logic [RUN_W-1:0]       pattern_len;
  } cfg_t;

  // Raw text compares, before the byte-count qualifiers
  typedef struct packed {
    logic pattern;
    logic send_ok;
    logic link;
    logic linked;
    logic unlink;
    logic data_ok;
  } match_t;

endpackage

// ===== hdl/at_response_stream_classifier.sv =====
// Top level of the serial response stream classifier: channel registers,
// handshakes and result register. Depends on arsc_pkg, arsc_cfg_regs, arsc_core.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------
//  in      | sink      | in_valid_i/stall_o | in_data_i  (req_type, rx_byte)
//  out     | source    | out_valid_o/stall_i| out_data_o (write + event info)
//  cfg     | sink      | cfg_we_i           | cfg_idx_i, cfg_wdata_i
//
// Every transfer in produces exactly one transfer out, through the input
// register, one step of compare logic and the result register. Sustained rate
// is one item per cycle unless out stalls; all state updates in the compare cycle.
// Reset clears mode, counters, byte window, line head and data-pending flag.
// A stalled result holds in the output register while one more item waits in
// the input register; input stalls only when both are full and out is stalled.
module at_response_stream_classifier (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // item channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  arsc_pkg::in_item_t              in_data_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output arsc_pkg::out_item_t             out_data_o,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [arsc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [arsc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import arsc_pkg::*;

  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q;
  out_item_t res;
  cfg_t      cfg;
  logic      advance;

  // Item in the input register moves on when the result register is free or draining
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  arsc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  arsc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A held input item must not be lost or altered while waiting
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> in_valid_q && $stable(in_q))
    else $error("input register changed while stalled");

  // Dropped bytes never produce a store write
  a_drop_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.write_valid |->
      (out_q.event_code != EV_RESP_OVF) && (out_q.event_code != EV_DATA_OVF) &&
      (out_q.event_code != EV_BUSY))
    else $error("write reported together with a drop event");

  // No write means zeroed write fields
  a_idle_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.write_valid |->
      !out_q.write_target && (out_q.write_index == '0) && (out_q.write_byte == 8'd0))
    else $error("write fields not cleared without a write");

  // Completion and send-ok both leave waiting mode
  a_done_leaves_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && ((out_q.event_code == EV_DONE) || (out_q.event_code == EV_SEND_OK))
      |-> !out_q.waiting)
    else $error("completion event while still waiting");

  // Response writes target the response store within its depth
  a_resp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> int'(out_q.response_count) <= int'(RESP_DEPTH))
    else $error("response count beyond store depth");

endmodule

// ===== hdl/arsc_cfg_regs.sv =====
// Configuration registers: completion pattern and its length.
// Depends on arsc_pkg.
module arsc_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [arsc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [arsc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output arsc_pkg::cfg_t                 cfg_o
);
  import arsc_pkg::*;

  logic [CFG_DATA_W-1:0] pat_lo_q, pat_hi_q;
  logic [RUN_W-1:0]      len_q, len_clamped;

  // length 0 acts as 1, anything above the window acts as the window
  always_comb begin
    if (cfg_wdata_i[4:0] == 5'd0) begin
      len_clamped = RUN_W'(1);
    end else if (int'(cfg_wdata_i[4:0]) > int'(WIN_BYTES)) begin
      len_clamped = RUN_W'(WIN_BYTES);
    end else begin
      len_clamped = RUN_W'(cfg_wdata_i[4:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      len_q    <= PAT_LEN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_PAT_LOW:  pat_lo_q <= cfg_wdata_i;
        CFG_PAT_HIGH: pat_hi_q <= cfg_wdata_i;
        CFG_PAT_LEN:  len_q    <= len_clamped;
        default: ;
      endcase
    end
  end

  assign cfg_o.pattern     = {pat_hi_q, pat_lo_q};
  assign cfg_o.pattern_len = len_q;

endmodule

// ===== hdl/arsc_match.sv =====
// Parallel text compares over the recent-byte window and the data line head.
// Depends on arsc_pkg.
module arsc_match (
  input  arsc_pkg::cfg_t                          cfg_i,
  input  logic [8*arsc_pkg::WIN_BYTES-1:0]         win_i,   // newest byte in 7:0
  input  logic [arsc_pkg::HEAD_BYTES-1:0][7:0]     head_i,
  output arsc_pkg::match_t                         match_o
);
  import arsc_pkg::*;

  logic [8*WIN_BYTES-1:0]  pat_rev, pat_shift;
  logic [WIN_BYTES-1:0]    byte_ok;
  logic [PAT_SH_W-1:0]     shamt;
  logic [8*HEAD_BYTES-1:0] head_str;

  // Reverse pattern byte order, then shift so its last byte meets the newest byte
  always_comb begin
    for (int k = 0; k < int'(WIN_BYTES); k++) begin
      pat_rev[8*k +: 8] = cfg_i.pattern[8*(int'(WIN_BYTES)-1-k) +: 8];
    end
    shamt     = PAT_SH_W'(int'(WIN_BYTES) - int'(cfg_i.pattern_len));
    pat_shift = pat_rev >> {shamt, 3'b000};
    for (int k = 0; k < int'(WIN_BYTES); k++) begin
      byte_ok[k] = (k >= int'(cfg_i.pattern_len)) || (win_i[8*k +: 8] == pat_shift[8*k +: 8]);
    end
  end

  // head byte 0 goes to the top so the string constants compare directly
  always_comb begin
    for (int k = 0; k < int'(HEAD_BYTES); k++) begin
      head_str[8*(int'(HEAD_BYTES)-1-k) +: 8] = head_i[k];
    end
  end

  assign match_o.pattern = &byte_ok;
  assign match_o.send_ok = (win_i[8*SEND_OK_LEN-1:0] == TXT_SEND_OK);
  assign match_o.data_ok = (win_i[8*DATA_OK_LEN-1:0] == TXT_DATA_OK);
  assign match_o.link    = (head_str[8*HEAD_BYTES-1 -: 8*LINK_LEN] == TXT_LINK);
  assign match_o.linked  = (head_str[8*HEAD_BYTES-1 -: 8*LINKED_LEN] == TXT_LINKED);
  assign match_o.unlink  = (head_str[8*HEAD_BYTES-1 -: 8*UNLINK_LEN] == TXT_UNLINK);

endmodule

// ===== hdl/arsc_core.sv =====
// Mode, fill counters, byte window and line head, with the per-item step logic.
// Depends on arsc_pkg and arsc_match.
module arsc_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  arsc_pkg::in_item_t   item_i,
  input  arsc_pkg::cfg_t       cfg_i,
  output arsc_pkg::out_item_t  res_o
);
  import arsc_pkg::*;

  mode_e                        mode_q, mode_d;
  logic [RESP_FILL_W-1:0]       resp_q, resp_d, resp_inc;
  logic [DATA_FILL_W-1:0]       data_q, data_d, data_inc;
  logic [8*WIN_BYTES-1:0]       win_q, win_d, win_push;
  logic [HEAD_BYTES-1:0][7:0]   head_q, head_d, head_push;
  logic                         pend_q, pend_d;
  logic [RUN_W-1:0]             run_q, run_d, run_inc;
  match_t                       match;
  event_e                       ev;
  logic                         wv, wt;
  logic [WIDX_W-1:0]            widx;

  // Candidate values if the byte is taken
  always_comb begin
    win_push  = {win_q[8*WIN_BYTES-9:0], item_i.rx_byte};
    run_inc   = (run_q == RUN_W'(WIN_BYTES)) ? run_q : run_q + 1'b1;
    resp_inc  = resp_q + 1'b1;
    data_inc  = data_q + 1'b1;
    head_push = head_q;
    if (data_q < DATA_FILL_W'(HEAD_BYTES)) begin
      head_push[data_q[HEAD_IDX_W-1:0]] = item_i.rx_byte;
    end
  end

  arsc_match u_match (
    .cfg_i   (cfg_i),
    .win_i   (win_push),
    .head_i  (head_push),
    .match_o (match)
  );

  always_comb begin
    mode_d = mode_q;
    resp_d = resp_q;
    data_d = data_q;
    win_d  = win_q;
    head_d = head_q;
    pend_d = pend_q;
    run_d  = run_q;
    ev     = EV_NONE;
    wv     = 1'b0;
    wt     = 1'b0;
    widx   = '0;
    case (req_e'(item_i.req_type))
      REQ_CAPTURE: begin
        resp_d = '0;
        mode_d = MODE_CAPTURE;
        run_d  = '0;
      end
      REQ_SEND_WAIT: begin
        resp_d = '0;
        data_d = '0;
        mode_d = MODE_SEND;
        run_d  = '0;
      end
      REQ_WAIT_END: begin
        mode_d = MODE_IDLE;
        run_d  = '0;
      end
      REQ_RELEASE: begin
        pend_d = 1'b0;
      end
      REQ_BYTE: begin
        case (mode_q)
          MODE_CAPTURE: begin
            if (resp_q >= RESP_FILL_W'(RESP_DEPTH)) begin
              ev = EV_RESP_OVF;
            end else begin
              wv     = 1'b1;
              widx   = WIDX_W'(resp_q);
              resp_d = resp_inc;
              win_d  = win_push;
              run_d  = run_inc;
              if (match.pattern && resp_inc >= RESP_FILL_W'(cfg_i.pattern_len) &&
                  run_inc >= cfg_i.pattern_len) begin
                ev     = EV_DONE;
                mode_d = MODE_IDLE;
                run_d  = '0;
              end
            end
          end
          MODE_SEND: begin
            win_d  = win_push;
            run_d  = run_inc;
            resp_d = (resp_q < RESP_FILL_W'(SEND_OK_LEN)) ? resp_inc : resp_q;
            if (match.send_ok && resp_d >= RESP_FILL_W'(SEND_OK_LEN) &&
                run_inc >= RUN_W'(SEND_OK_LEN)) begin
              ev     = EV_SEND_OK;
              mode_d = MODE_IDLE;
              run_d  = '0;
            end
          end
          default: begin
            if (pend_q) begin
              ev = EV_BUSY;
            end else if (data_q >= DATA_FILL_W'(DATA_DEPTH)) begin
              ev = EV_DATA_OVF;
            end else begin
              wv     = 1'b1;
              wt     = 1'b1;
              widx   = WIDX_W'(data_q);
              head_d = head_push;
              data_d = data_inc;
              win_d  = win_push;
              run_d  = run_inc;
              if ((match.link && data_inc >= DATA_FILL_W'(LINK_LEN)) ||
                  (match.linked && data_inc >= DATA_FILL_W'(LINKED_LEN))) begin
                ev     = EV_LINK;
                data_d = '0;
              end else if (match.unlink && data_inc >= DATA_FILL_W'(UNLINK_LEN)) begin
                ev     = EV_UNLINK;
                data_d = '0;
              end else if (match.data_ok && data_inc >= DATA_FILL_W'(DATA_OK_LEN) &&
                           run_inc >= RUN_W'(DATA_OK_LEN)) begin
                ev     = EV_DATA_READY;
                pend_d = 1'b1;
                data_d = '0;
              end
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      resp_q <= '0;
      data_q <= '0;
      win_q  <= '0;
      head_q <= '0;
      pend_q <= 1'b0;
      run_q  <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      resp_q <= resp_d;
      data_q <= data_d;
      win_q  <= win_d;
      head_q <= head_d;
      pend_q <= pend_d;
      run_q  <= run_d;
    end
  end

  assign res_o.write_valid    = wv;
  assign res_o.write_target   = wt;
  assign res_o.write_index    = widx;
  assign res_o.write_byte     = wv ? item_i.rx_byte : 8'd0;
  assign res_o.event_code     = ev;
  assign res_o.response_count = CNT_W'(resp_d);
  assign res_o.waiting        = (mode_d != MODE_IDLE);

endmodule

// ===== dv/arsc_reply_check.sv =====
`timescale 1ns / 100ps
// Result checker for the serial response stream classifier: watches the item,
// result and register channels, predicts every result and compares it.
// Depends on arsc_pkg for channel types, codes and store depths.
module arsc_reply_check (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  arsc_pkg::in_item_t              in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  arsc_pkg::out_item_t             out_data_i,
  input  logic                            cfg_we_i,
  input  logic [arsc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [arsc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int unsigned                     mismatch_count_o,
  output int unsigned                     pending_o
);
  import arsc_pkg::*;

  localparam int unsigned WIN       = 16;
  localparam int unsigned HEAD      = 8;
  localparam int unsigned MSG_LIMIT = 40;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef logic [8*WIN-1:0] text_t;

  // fixed replies, first character in the top byte
  localparam logic [8*9-1:0] SEND_OK_TEXT = {"SEND OK", CH_CR, CH_LF};
  localparam logic [8*6-1:0] LINK_TEXT    = {"Link", CH_CR, CH_LF};
  localparam logic [8*8-1:0] LINKED_TEXT  = {"Linked", CH_CR, CH_LF};
  localparam logic [8*8-1:0] UNLINK_TEXT  = {"Unlink", CH_CR, CH_LF};
  localparam logic [8*6-1:0] DATA_OK_TEXT = {CH_CR, CH_LF, "OK", CH_CR, CH_LF};

  text_t       pat_bytes;
  logic [4:0]  pat_len_raw;
  mode_e       mode;
  int unsigned resp_fill;
  int unsigned data_fill;
  int unsigned run_len;
  logic [7:0]  recent [WIN];
  logic [7:0]  line_head [HEAD];
  logic        data_pending;
  out_item_t   result_q [$];

  function automatic void clear_state();
    pat_bytes    = '0;
    pat_len_raw  = 5'd4;
    mode         = MODE_IDLE;
    resp_fill    = 0;
    data_fill    = 0;
    run_len      = 0;
    data_pending = 1'b0;
    foreach (recent[i]) recent[i] = '0;
    foreach (line_head[i]) line_head[i] = '0;
  endfunction

  function automatic void enter_mode(mode_e m);
    mode    = m;
    run_len = 0;
  endfunction

  function automatic void push_recent(logic [7:0] b);
    for (int i = 0; i < WIN - 1; i++) recent[i] = recent[i+1];
    recent[WIN-1] = b;
    if (run_len < WIN) run_len++;
  endfunction

  // newest n received bytes against a right-aligned text
  function automatic bit tail_is(text_t txt, int unsigned n);
    for (int k = 0; k < n; k++)
      if (recent[WIN-n+k] != txt[8*(n-1-k) +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit head_is(text_t txt, int unsigned n);
    if (data_fill < n) return 1'b0;
    for (int k = 0; k < n; k++)
      if (line_head[k] != txt[8*(n-1-k) +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit pattern_hit();
    int unsigned len;
    len = pat_len_raw;
    if (len == 0) len = 1;
    if (len > WIN) len = WIN;
    if (resp_fill < len || run_len < len) return 1'b0;
    for (int i = 0; i < len; i++)
      if (recent[WIN-len+i] != pat_bytes[8*i +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  // one step of the classifier; updates the predicted state
  function automatic out_item_t classify(in_item_t item);
    out_item_t r;
    logic [7:0] b;
    r = '0;
    b = item.rx_byte;
    case (item.req_type)
      REQ_CAPTURE: begin
        resp_fill = 0;
        enter_mode(MODE_CAPTURE);
      end
      REQ_SEND_WAIT: begin
        resp_fill = 0;
        data_fill = 0;
        enter_mode(MODE_SEND);
      end
      REQ_WAIT_END: enter_mode(MODE_IDLE);
      REQ_RELEASE:  data_pending = 1'b0;
      REQ_BYTE: begin
        if (mode == MODE_CAPTURE) begin
          if (resp_fill >= RESP_DEPTH) begin
            r.event_code = EV_RESP_OVF;
          end else begin
            r.write_valid  = 1'b1;
            r.write_target = 1'b0;
            r.write_index  = WIDX_W'(resp_fill);
            r.write_byte   = b;
            resp_fill++;
            push_recent(b);
            if (pattern_hit()) begin
              r.event_code = EV_DONE;
              enter_mode(MODE_IDLE);
            end
          end
        end else if (mode == MODE_SEND) begin
          push_recent(b);
          if (resp_fill < 9) resp_fill++;
          if (resp_fill >= 9 && run_len >= 9 && tail_is(SEND_OK_TEXT, 9)) begin
            r.event_code = EV_SEND_OK;
            enter_mode(MODE_IDLE);
          end
        end else if (data_pending) begin
          r.event_code = EV_BUSY;
        end else if (data_fill >= DATA_DEPTH) begin
          r.event_code = EV_DATA_OVF;
        end else begin
          r.write_valid  = 1'b1;
          r.write_target = 1'b1;
          r.write_index  = WIDX_W'(data_fill);
          r.write_byte   = b;
          if (data_fill < HEAD) line_head[data_fill] = b;
          data_fill++;
          push_recent(b);
          if (data_fill >= 6) begin
            if (head_is(LINK_TEXT, 6) || head_is(LINKED_TEXT, 8)) begin
              r.event_code = EV_LINK;
              data_fill    = 0;
            end else if (head_is(UNLINK_TEXT, 8)) begin
              r.event_code = EV_UNLINK;
              data_fill    = 0;
            end else if (run_len >= 6 && tail_is(DATA_OK_TEXT, 6)) begin
              r.event_code = EV_DATA_READY;
              data_pending = 1'b1;
              data_fill    = 0;
            end
          end
        end
      end
      default: ;
    endcase
    r.response_count = CNT_W'(resp_fill);
    r.waiting        = (mode == MODE_CAPTURE || mode == MODE_SEND);
    return r;
  endfunction

  task automatic report(string msg);
    if (mismatch_count_o < MSG_LIMIT) $display("%0t ns: %s", $time, msg);
    mismatch_count_o++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) report($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  task automatic compare(out_item_t got, out_item_t want);
    check_field("write_valid", got.write_valid, want.write_valid);
    check_field("write_target", got.write_target, want.write_target);
    check_field("write_index", got.write_index, want.write_index);
    check_field("write_byte", got.write_byte, want.write_byte);
    check_field("event_code", got.event_code, want.event_code);
    check_field("response_count", got.response_count, want.response_count);
    check_field("waiting", got.waiting, want.waiting);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      result_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PAT_LOW:  pat_bytes[63:0]   = cfg_wdata_i;
          CFG_PAT_HIGH: pat_bytes[127:64] = cfg_wdata_i;
          CFG_PAT_LEN:  pat_len_raw       = cfg_wdata_i[4:0];
          default: ;
        endcase
      end
      // a result never leaves on the edge its item arrives, so pop first
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0)
          report($sformatf("result with nothing pending, event %0h",
                           out_data_i.event_code));
        else
          compare(out_data_i, result_q.pop_front());
      end
      if (in_valid_i && !in_stall_i) result_q.push_back(classify(in_data_i));
      pending_o <= result_q.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Top of the classifier testbench: clock, reset, item and register stimulus,
// random result stalls and the verdict. Depends on arsc_pkg, arsc_reply_check
// and the block itself.
module testbench;
  import arsc_pkg::*;

  localparam int unsigned RESET_CYCLES      = 6;
  localparam int unsigned CYCLE_LIMIT       = 200000;
  localparam int unsigned DRAIN_CYCLES      = 8;   // two-stage pipe plus slack
  localparam int unsigned NUM_SETTINGS      = 8;
  localparam int unsigned ITEMS_PER_SETTING = 75;
  localparam int unsigned RESP_FLOOD        = RESP_DEPTH + 6;
  localparam int unsigned DATA_FLOOD        = DATA_DEPTH + 6;
  localparam int unsigned PAT_MAX           = 16;

  // request codes with no meaning; the block must ignore them
  localparam int unsigned REQ_UNUSED_FIRST = 5;
  localparam int unsigned REQ_CODE_LAST    = 7;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int unsigned mismatches;
  int unsigned pending;

  bit          gaps_on;
  bit          stalls_on;
  int unsigned stall_left;
  int unsigned cycles;
  int unsigned items_sent;
  int unsigned setting_items;
  int unsigned settings_used;

  // pattern currently loaded, for building well-formed replies
  logic [8*PAT_MAX-1:0] cur_pattern = '0;
  int unsigned          cur_len     = 4;

  // characters that steer the line and reply compares
  string noise_chars = "OKLinkedUnlSEND +";

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  at_response_stream_classifier DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  arsc_reply_check reply_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  // Result side: random stall bursts while stalls_on is set. A burst
  // that is running when stalls_on drops still runs out.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      if (stall_left == 0) out_stall <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 9);
      out_stall <= 1'b1;
    end
  end

  // Hard stop: hung handshake or lost results
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("testbench failed");
      $finish;
    end
  end

  // One transfer on the item channel. Valid stays high after the transfer so
  // back-to-back items go out with no bubble; a gap burst lowers it.
  task automatic send(logic [2:0] req, logic [7:0] b);
    in_valid <= 1'b1;
    in_data  <= {req, b};
    do @(posedge clk); while (in_stall);
    items_sent++;
    setting_items++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // control requests carry a junk byte that must be ignored
  task automatic send_ctrl(req_e r);
    send(r, 8'($urandom));
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send(REQ_BYTE, s[i]);
  endtask

  task automatic send_crlf();
    send(REQ_BYTE, CR);
    send(REQ_BYTE, LF);
  endtask

  // CR LF "OK" CR LF: ends a data line with a data-ready report
  task automatic send_data_ok();
    send_crlf();
    send_text("OK");
    send_crlf();
  endtask

  function automatic logic [7:0] noise_byte();
    int unsigned pick;
    pick = $urandom_range(0, 5);
    if (pick < 3) return 8'($urandom_range(0, 255));
    if (pick == 3) return $urandom_range(0, 1) ? CR : LF;
    return noise_chars[$urandom_range(0, noise_chars.len() - 1)];
  endfunction

  // Stop sending and wait for every predicted result, then idle on so the
  // block is quiet before any register write.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Loads all three pattern registers on consecutive edges. The length word
  // sometimes carries junk above bit 4, which the block must drop.
  task automatic load_pattern(logic [63:0] lo, logic [63:0] hi, logic [4:0] len);
    logic [63:0] len_word;
    len_word = {$urandom, $urandom};
    if ($urandom_range(0, 1)) len_word = '0;
    len_word[4:0] = len;
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_PAT_LOW;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_idx   <= CFG_PAT_HIGH;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_idx   <= CFG_PAT_LEN;
    cfg_wdata <= len_word;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_pattern = {hi, lo};
    cur_len     = (len == 0) ? 1 : ((len > PAT_MAX) ? PAT_MAX : len);
    settings_used++;
  endtask

  task automatic shuffle_idling(bit quiet);
    gaps_on   = !quiet && $urandom_range(0, 2) != 0;
    stalls_on <= !quiet && $urandom_range(0, 2) != 0;
  endtask

  // Captured reply: filler, then either the loaded pattern (done) or an
  // abandoned capture closed by wait-ended.
  task automatic capture_reply(bit complete);
    int unsigned i;
    send_ctrl(REQ_CAPTURE);
    repeat ($urandom_range(0, 12)) send(REQ_BYTE, noise_byte());
    if (complete) begin
      for (i = 0; i < cur_len; i++) send(REQ_BYTE, cur_pattern[8*i +: 8]);
    end else begin
      send_ctrl(REQ_WAIT_END);
    end
  endtask

  // Send-wait: noise, then SEND OK CR LF, one byte flipped when broken
  task automatic send_wait_reply(bit intact);
    logic [8*9-1:0] txt;
    logic [7:0]     b;
    int unsigned    bad;
    int unsigned    i;
    txt = {"SEND OK", CR, LF};
    bad = $urandom_range(0, 8);
    send_ctrl(REQ_SEND_WAIT);
    repeat ($urandom_range(0, 10)) send(REQ_BYTE, noise_byte());
    for (i = 0; i < 9; i++) begin
      b = txt[8*(8-i) +: 8];
      if (!intact && i == bad) b = b ^ 8'($urandom_range(1, 255));
      send(REQ_BYTE, b);
    end
    if (!intact || $urandom_range(0, 3) == 0) send_ctrl(REQ_WAIT_END);
  endtask

  initial begin
    int unsigned s;
    int unsigned r;
    bit          last_setting;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- Directed part, reset register values (zero pattern, length 4) ----
    gaps_on = 1'b0;
    // byte extremes land in the incoming data store
    send(REQ_BYTE, 8'h00);
    send(REQ_BYTE, 8'hFF);
    // unused request codes: no write, no event
    for (r = REQ_UNUSED_FIRST; r <= REQ_CODE_LAST; r++) send(3'(r), 8'hA5);
    // capture completes on four zero bytes
    send_ctrl(REQ_CAPTURE);
    repeat (4) send(REQ_BYTE, 8'h00);
    // send-wait hit on the first full window, back to idle
    send_ctrl(REQ_SEND_WAIT);
    send_text("SEND OK");
    send_crlf();
    // send-wait cleared the data fill, so this is a fresh line: link
    send_text("Link");
    send_crlf();

    // ---- Random part: one block of traffic per pattern setting ----
    for (s = 0; s < NUM_SETTINGS; s++) begin
      last_setting = (s == NUM_SETTINGS - 1);
      // sender holds off until every result is back; registers change idle
      drain();
      case (s)
        0: load_pattern({16'h0000, LF, CR, "K", "O", LF, CR}, {$urandom, $urandom}, 5'd6);
        1: load_pattern('1, '1, 5'd16);
        2: load_pattern({$urandom, $urandom}, {$urandom, $urandom}, 5'd0);
        3: load_pattern({$urandom, $urandom}, {$urandom, $urandom}, 5'd31);
        4: load_pattern('0, '0, 5'd1);
        5: load_pattern({$urandom, $urandom}, {$urandom, $urandom}, 5'd17);
        default: load_pattern({$urandom, $urandom}, {$urandom, $urandom},
                              5'($urandom_range(0, 31)));
      endcase
      shuffle_idling(last_setting);

      // response store overflow: all-ones pattern of 16 never matches noise
      if (s == 1) begin
        send_ctrl(REQ_CAPTURE);
        repeat (RESP_FLOOD) send(REQ_BYTE, 8'($urandom_range(0, 255)));
        send_ctrl(REQ_WAIT_END);
      end
      // data store overflow: start a clean line, fill past the end, then
      // recover through send-wait, which is the only thing that clears it
      if (s == 3) begin
        send_ctrl(REQ_WAIT_END);
        send_ctrl(REQ_RELEASE);
        send_data_ok();
        send_ctrl(REQ_RELEASE);
        send(REQ_BYTE, "x");
        repeat (DATA_FLOOD) send(REQ_BYTE, 8'($urandom_range(0, 255)));
        send_ctrl(REQ_SEND_WAIT);
        send_ctrl(REQ_WAIT_END);
      end

      setting_items = 0;
      while (setting_items < ITEMS_PER_SETTING) begin
        case ($urandom_range(0, 9))
          0, 1: capture_reply(1'b1);
          2:    capture_reply(1'b0);
          3, 4: send_wait_reply(1'b1);
          5:    send_wait_reply(1'b0);
          6: begin
            // data message; left pending now and then so the next bytes hit busy
            send_ctrl(REQ_WAIT_END);
            if ($urandom_range(0, 4) != 0) send_ctrl(REQ_RELEASE);
            send_text("+IPD,");
            repeat ($urandom_range(0, 16)) send(REQ_BYTE, noise_byte());
            send_data_ok();
            if ($urandom_range(0, 2) != 0) send_ctrl(REQ_RELEASE);
          end
          7, 8: begin
            // link/unlink lines need a fresh line head; usually flush first
            send_ctrl(REQ_WAIT_END);
            if ($urandom_range(0, 3) != 0) begin
              send_ctrl(REQ_RELEASE);
              send_data_ok();
              send_ctrl(REQ_RELEASE);
            end
            case ($urandom_range(0, 3))
              0:       send_text("Link");
              1:       send_text("Linked");
              2:       send_text("Unlink");
              default: send_text("Lin");   // truncated line, no report
            endcase
            send_crlf();
          end
          default: begin
            // raw noise: any request code, any byte, any mode
            repeat ($urandom_range(1, 12)) begin
              if ($urandom_range(0, 9) < 6) send(REQ_BYTE, noise_byte());
              else send(3'($urandom_range(1, REQ_CODE_LAST)), 8'($urandom));
            end
          end
        endcase
        // every scenario sends at least one item, so a clock edge has passed
        shuffle_idling(last_setting);
      end
    end

    drain();
    $display("%0d items over %0d pattern settings: captures, send waits, link and data",
             items_sent, settings_used);
    $display("lines, busy drops and both store overflows; %0d mismatches", mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
